[rtl/hpp_pkg.sv]
// Shared constants and types for the hex polynomial text parser.
package hpp_pkg;

  // Powers must stay strictly below this limit; the power accumulator saturates here.
  localparam int PowerLimit = 65536;
  // Coefficient register width.
  localparam int CoeffBits = 64;
  // Width of the power accumulator, the previous power and the first term count.
  localparam int PowerW = $clog2(PowerLimit + 1);

  // Fixed widths of the result fields.
  localparam int TermPowerW = 16;
  localparam int TermCoefW = 64;
  localparam int CountW = 17;
  localparam int StatusW = 2;

  // Depth of the queue between the parser and the output stage.
  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);

  // Summary status codes.
  localparam logic [StatusW-1:0] StOk = 2'd0;
  localparam logic [StatusW-1:0] StNtt = 2'd1;
  localparam logic [StatusW-1:0] StParse = 2'd2;
  localparam logic [StatusW-1:0] StWide = 2'd3;

  // Result kinds as carried on the output tuser.
  localparam logic KindTerm = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Request kinds as carried on the input tuser.
  localparam logic ReqChar = 1'b0;
  localparam logic ReqEnd = 1'b1;

  // One queue entry: an optional term result followed by an optional summary.
  typedef struct packed {
    logic                  has_term;
    logic                  has_sum;
    logic [TermPowerW-1:0] power;
    logic [TermCoefW-1:0]  coef;
    logic [CountW-1:0]     count;
    logic                  all_zero;
    logic [StatusW-1:0]    status;
  } qentry_t;

endpackage

[rtl/hpp_front.sv]
// Character parser: runs the grammar state machine and builds queue entries.
module hpp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              take,
  input  logic              req_type,
  input  logic [7:0]        char_code,
  output logic              push,
  output hpp_pkg::qentry_t  push_data
);

  localparam logic [2:0] PhCoefStart = 3'd0;
  localparam logic [2:0] PhInCoef = 3'd1;
  localparam logic [2:0] PhExpectCaret = 3'd2;
  localparam logic [2:0] PhInPower = 3'd3;
  localparam logic [2:0] PhExpectPlus = 3'd4;
  localparam logic [2:0] PhExpectSpace = 3'd5;

  localparam logic [7:0] ChX = 8'h78;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  localparam int PW = hpp_pkg::PowerW;
  localparam int CB = hpp_pkg::CoeffBits;

  logic          ntt_form;
  logic [2:0]    phase, phase_next;
  logic [CB-1:0] acc, acc_next;
  logic          wide, wide_next;
  logic          nz, nz_next;
  logic [PW-1:0] pacc, pacc_next;
  logic [PW-1:0] prev, prev_next;
  logic [PW-1:0] ftc, ftc_next;
  logic          fail, fail_next;

  logic          hex_ok;
  logic [3:0]    hex_val;
  logic          is_dec;
  logic [3:0]    dec_val;
  logic [PW+3:0] p10;
  logic          fin_req;
  logic          fin_ok;
  logic [PW-1:0] fin_pw;
  logic          sum_req;
  logic          zero_poly;

  // Character classification.
  always_comb begin
    hex_ok = 1'b1;
    hex_val = 4'd0;
    if (char_code >= ChZero && char_code <= ChNine) begin
      hex_val = 4'(char_code - ChZero);
    end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
      hex_val = 4'(char_code - 8'h37);
    end else if (char_code >= 8'h61 && char_code <= 8'h66) begin
      hex_val = 4'(char_code - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
    is_dec = (char_code >= ChZero) && (char_code <= ChNine);
    dec_val = 4'(char_code - ChZero);
    p10 = ({4'b0, pacc} << 3) + ({4'b0, pacc} << 1) + (PW+4)'(dec_val);
  end

  // Grammar step, term completion and summary.
  always_comb begin
    phase_next = phase;
    acc_next = acc;
    wide_next = wide;
    nz_next = nz;
    pacc_next = pacc;
    prev_next = prev;
    ftc_next = ftc;
    fail_next = fail;
    fin_req = 1'b0;
    fin_pw = '0;
    sum_req = 1'b0;
    push_data = '0;

    if (take) begin
      if (req_type == hpp_pkg::ReqChar) begin
        if (!fail) begin
          case (phase)
            PhCoefStart: begin
              if (hex_ok) begin
                acc_next = CB'(hex_val);
                if (hex_val != 4'd0) nz_next = 1'b1;
                phase_next = PhInCoef;
              end else begin
                fail_next = 1'b1;
              end
            end
            PhInCoef: begin
              if (hex_ok) begin
                if (acc[CB-1:CB-4] != 4'd0) wide_next = 1'b1;
                acc_next = {acc[CB-5:0], hex_val};
                if (hex_val != 4'd0) nz_next = 1'b1;
              end else if (char_code == ChX) begin
                phase_next = PhExpectCaret;
              end else begin
                fail_next = 1'b1;
              end
            end
            PhExpectCaret: begin
              if (char_code == ChCaret) begin
                pacc_next = '0;
                phase_next = PhInPower;
              end else begin
                fail_next = 1'b1;
              end
            end
            PhInPower: begin
              if (is_dec) begin
                if (p10 > (PW+4)'(hpp_pkg::PowerLimit)) begin
                  pacc_next = PW'(hpp_pkg::PowerLimit);
                end else begin
                  pacc_next = PW'(p10);
                end
              end else if (char_code == ChSpace) begin
                fin_req = 1'b1;
                fin_pw = pacc;
                phase_next = PhExpectPlus;
              end else begin
                fail_next = 1'b1;
              end
            end
            PhExpectPlus: begin
              if (char_code == ChPlus) phase_next = PhExpectSpace;
              else fail_next = 1'b1;
            end
            PhExpectSpace: begin
              if (char_code == ChSpace) phase_next = PhCoefStart;
              else fail_next = 1'b1;
            end
            default: begin
              fail_next = 1'b1;
            end
          endcase
        end
      end else begin
        sum_req = 1'b1;
        if (!fail) begin
          case (phase)
            PhCoefStart: begin
            end
            PhInCoef: begin
              fin_req = 1'b1;
              fin_pw = '0;
            end
            PhInPower: begin
              fin_req = 1'b1;
              fin_pw = pacc;
            end
            default: begin
              fail_next = 1'b1;
            end
          endcase
        end
      end
    end

    // A term is accepted only when its power is below the previous one.
    fin_ok = fin_req && (fin_pw < prev);
    if (fin_req && !fin_ok) fail_next = 1'b1;
    if (fin_ok) begin
      if (ftc == '0) ftc_next = PW'(fin_pw + PW'(1));
      prev_next = fin_pw;
    end

    push_data.has_term = fin_ok;
    push_data.has_sum = sum_req;
    if (fin_ok) begin
      push_data.power = hpp_pkg::TermPowerW'(fin_pw);
      push_data.coef = hpp_pkg::TermCoefW'(acc);
    end

    // Summary status by priority: transformed form, parse error, all zero, too wide.
    zero_poly = (ftc_next == '0) || !nz;
    if (ntt_form) begin
      push_data.status = hpp_pkg::StNtt;
    end else if (fail_next) begin
      push_data.status = hpp_pkg::StParse;
    end else if (zero_poly) begin
      push_data.status = hpp_pkg::StOk;
      push_data.all_zero = 1'b1;
      push_data.count = hpp_pkg::CountW'(ftc_next);
    end else if (wide) begin
      push_data.status = hpp_pkg::StWide;
      push_data.count = hpp_pkg::CountW'(ftc_next);
    end else begin
      push_data.status = hpp_pkg::StOk;
      push_data.count = hpp_pkg::CountW'(ftc_next);
    end
    if (!sum_req) begin
      push_data.status = hpp_pkg::StOk;
      push_data.all_zero = 1'b0;
      push_data.count = '0;
    end

    // The end of the string readies the parser for the next one.
    if (sum_req) begin
      phase_next = PhCoefStart;
      acc_next = '0;
      wide_next = 1'b0;
      nz_next = 1'b0;
      pacc_next = '0;
      prev_next = PW'(hpp_pkg::PowerLimit);
      ftc_next = '0;
      fail_next = 1'b0;
    end
  end

  assign push = take && (fin_ok || sum_req);

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ntt_form <= 1'b0;
      phase <= PhCoefStart;
      acc <= '0;
      wide <= 1'b0;
      nz <= 1'b0;
      pacc <= '0;
      prev <= PW'(hpp_pkg::PowerLimit);
      ftc <= '0;
      fail <= 1'b0;
    end else begin
      if (cfg_we) ntt_form <= cfg_wdata;
      phase <= phase_next;
      acc <= acc_next;
      wide <= wide_next;
      nz <= nz_next;
      pacc <= pacc_next;
      prev <= prev_next;
      ftc <= ftc_next;
      fail <= fail_next;
    end
  end

endmodule

[rtl/hpp_queue.sv]
// Small register queue between the parser and the output stage.
module hpp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hpp_pkg::qentry_t  push_data,
  input  logic              pop,
  output hpp_pkg::qentry_t  head,
  output logic              empty,
  output logic              full
);

  localparam int Aw = hpp_pkg::QAw;

  hpp_pkg::qentry_t mem [hpp_pkg::QDepth];
  logic [Aw-1:0] wr_ptr;
  logic [Aw-1:0] rd_ptr;
  logic [Aw:0]   cnt;
  logic          do_push;
  logic          do_pop;

  assign empty = (cnt == '0);
  assign full = (cnt == (Aw+1)'(hpp_pkg::QDepth));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + Aw'(1);
      if (do_pop) rd_ptr <= rd_ptr + Aw'(1);
      if (do_push && !do_pop) cnt <= cnt + (Aw+1)'(1);
      else if (do_pop && !do_push) cnt <= cnt - (Aw+1)'(1);
    end
  end

  // The fill count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (Aw+1)'(hpp_pkg::QDepth))
    else $error("queue fill count above depth");

  // A push into a full queue would be lost.
  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  // A push without a pop grows the count by one.
  a_cnt_grow: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> cnt == $past(cnt) + (Aw+1)'(1))
    else $error("fill count did not grow on push");

endmodule

[rtl/hpp_back.sv]
// Output stage: expands queue entries into term and summary transactions.
module hpp_back (
  input  logic              clk,
  input  logic              rst,
  input  hpp_pkg::qentry_t  head,
  input  logic              empty,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [103:0]      m_tdata,
  output logic              m_tuser,
  output logic              m_tlast
);

  hpp_pkg::qentry_t ent;
  logic busy;
  logic term_pend;
  logic xfer;
  logic done;

  assign xfer = busy && m_tready;
  // The entry is finished after its summary, or after a term with no summary.
  assign done = xfer && !(term_pend && ent.has_sum);
  assign pop = (!busy || done) && !empty;

  assign m_tvalid = busy;
  assign m_tuser = term_pend ? hpp_pkg::KindTerm : hpp_pkg::KindSummary;
  assign m_tlast = term_pend ? !ent.has_sum : 1'b1;

  // Term results carry power and coefficient; summaries carry count, flag and status.
  always_comb begin
    if (term_pend) begin
      m_tdata = {4'b0, hpp_pkg::StOk, 1'b0, 17'd0, ent.coef, ent.power};
    end else begin
      m_tdata = {4'b0, ent.status, ent.all_zero, ent.count, 64'd0, 16'd0};
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      term_pend <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
      term_pend <= head.has_term;
    end else if (done) begin
      busy <= 1'b0;
      term_pend <= 1'b0;
    end else if (xfer) begin
      term_pend <= 1'b0;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    if (pop) ent <= head;
  end

  // A held entry always has something to send.
  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (ent.has_term || ent.has_sum))
    else $error("held entry carries no result");

  // Once the term is gone, what remains must be a summary.
  a_summary_left: assert property (@(posedge clk) disable iff (rst)
    (busy && !term_pend) |-> ent.has_sum)
    else $error("summary phase without summary");

  // A waiting entry follows a completed one without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (done && !empty) |=> m_tvalid)
    else $error("output idle while queue holds entries");

endmodule

[rtl/hex_polynomial_text_parser.sv]
// Top level of the hex polynomial text parser.
//
//  Channel  Dir  Handshake          Contents
//  cfg      in   cfg_we             cfg_wdata = ntt_form
//  s        in   s_tvalid/s_tready  tuser = req_type, tdata[7:0] = char_code
//  m        out  m_tvalid/m_tready  tuser = result_kind, tlast = last,
//                                   tdata = power, coefficient, count, all_zero, status
//
// One input transaction is taken per cycle while the queue is not full; the parser state
// machine steps once per taken transaction. A transaction that completes a term or ends
// the string is written into a four-entry queue; the output stage loads queue entries into
// its entry register, and an end of string with a pending term is sent as a term, then a summary.
// Synchronous reset returns the parser to the start of a string and empties the queue.
// s_tready drops only while the queue is full; the output stalls freely on m_tready.
module hex_polynomial_text_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,   // ntt_form
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,     // [7:0] char_code
  input  logic          s_tuser,     // [0] req_type
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,     // [15:0] term_power, [79:16] term_coefficient,
                                     // [96:80] coefficient_count, [97] all_zero,
                                     // [99:98] status, [103:100] zero
  output logic          m_tuser,     // [0] result_kind
  output logic          m_tlast
);

  hpp_pkg::qentry_t push_data;
  hpp_pkg::qentry_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;
  logic take;

  assign s_tready = !full;
  assign take = s_tvalid && s_tready;

  // Parser front end.
  hpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .req_type  (s_tuser),
    .char_code (s_tdata),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue.
  hpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // Result output stage.
  hpp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[verif/hex_polynomial_text_parser_test.sv]
// Self-checking stream testbench for the hex polynomial text parser.
module hex_polynomial_text_parser_test;
  import hpp_pkg::*;

  localparam int HalfPeriod = 4;
  localparam int HoldCycles = 160;
  localparam int DrainCycles = 12;
  localparam int StallLimit = 2000;
  localparam int PhaseItems = 180;

  // Characters of the grammar.
  localparam logic [7:0] ChX = "x";
  localparam logic [7:0] ChCaret = "^";
  localparam logic [7:0] ChPlus = "+";
  localparam logic [7:0] ChSpace = " ";
  localparam logic [7:0] Ch0 = "0";
  localparam logic [7:0] Ch9 = "9";

  typedef enum logic [2:0] {
    PhCoefStart,
    PhInCoef,
    PhExpectCaret,
    PhInPower,
    PhExpectPlus,
    PhExpectSpace
  } parse_phase_e;

  typedef struct {
    logic                  kind;
    logic [TermPowerW-1:0] power;
    logic [TermCoefW-1:0]  coef;
    logic [CountW-1:0]     count;
    logic                  all_zero;
    logic [StatusW-1:0]    status;
    logic                  last;
  } poly_result_t;

  // Tracks the parser state and the results each accepted request should produce.
  class parse_scoreboard;
    logic                 ntt_form;
    parse_phase_e         phase;
    logic [CoeffBits-1:0] coef_acc;
    logic                 coef_wide;
    logic                 any_nonzero;
    logic                 failed;
    int unsigned          power_acc;
    int unsigned          prev_power;
    int unsigned          first_count;
    poly_result_t         due_results[$];
    int                   errors;
    int                   live_items;

    function new();
      ntt_form = 1'b0;
      errors = 0;
      live_items = 0;
      restart();
    endfunction

    function void restart();
      phase = PhCoefStart;
      coef_acc = '0;
      coef_wide = 1'b0;
      any_nonzero = 1'b0;
      failed = 1'b0;
      power_acc = 0;
      prev_power = PowerLimit;
      first_count = 0;
    endfunction

    function int hex_nibble(logic [7:0] c);
      if (c >= Ch0 && c <= Ch9) return int'(c - Ch0);
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
    endfunction

    function void push_result(logic kind, int unsigned pw, logic [TermCoefW-1:0] coef,
                              int unsigned count, logic az, logic [StatusW-1:0] st,
                              logic last_flag);
      poly_result_t r;
      r.kind = kind;
      r.power = TermPowerW'(pw);
      r.coef = coef;
      r.count = CountW'(count);
      r.all_zero = az;
      r.status = st;
      r.last = last_flag;
      due_results.push_back(r);
    endfunction

    // A finished term is kept only if its power is below the previous one.
    function void close_term(int unsigned pw, logic last_flag);
      if (pw >= prev_power) begin
        failed = 1'b1;
        return;
      end
      if (first_count == 0) first_count = pw + 1;
      prev_power = pw;
      push_result(KindTerm, pw, coef_acc, 0, 1'b0, StOk, last_flag);
    endfunction

    // Advances the parser by one accepted request and queues what it produces.
    function void note_request(logic req, logic [7:0] c);
      int nib;
      int unsigned p;
      int unsigned count;
      logic az;
      logic [StatusW-1:0] st;
      live_items++;
      if (req == ReqChar) begin
        // Once the string is broken, characters are dropped until its end.
        if (failed) return;
        nib = hex_nibble(c);
        case (phase)
          PhCoefStart: begin
            if (nib >= 0) begin
              coef_acc = CoeffBits'(nib);
              if (nib != 0) any_nonzero = 1'b1;
              phase = PhInCoef;
            end else begin
              failed = 1'b1;
            end
          end
          PhInCoef: begin
            if (nib >= 0) begin
              if ((coef_acc >> (CoeffBits - 4)) != 0) coef_wide = 1'b1;
              coef_acc = (coef_acc << 4) | CoeffBits'(nib);
              if (nib != 0) any_nonzero = 1'b1;
            end else if (c == ChX) begin
              phase = PhExpectCaret;
            end else begin
              failed = 1'b1;
            end
          end
          PhExpectCaret: begin
            if (c == ChCaret) begin
              power_acc = 0;
              phase = PhInPower;
            end else begin
              failed = 1'b1;
            end
          end
          PhInPower: begin
            if (c >= Ch0 && c <= Ch9) begin
              p = power_acc * 10 + int'(c - Ch0);
              power_acc = (p > PowerLimit) ? PowerLimit : p;
            end else if (c == ChSpace) begin
              close_term(power_acc, 1'b1);
              phase = PhExpectPlus;
            end else begin
              failed = 1'b1;
            end
          end
          PhExpectPlus: begin
            if (c == ChPlus) phase = PhExpectSpace;
            else failed = 1'b1;
          end
          PhExpectSpace: begin
            if (c == ChSpace) phase = PhCoefStart;
            else failed = 1'b1;
          end
          default: failed = 1'b1;
        endcase
        return;
      end

      // End of string: close a pending term, then summarize.
      if (!failed) begin
        case (phase)
          PhCoefStart: begin
          end
          PhInCoef: close_term(0, 1'b0);
          PhInPower: close_term(power_acc, 1'b0);
          default: failed = 1'b1;
        endcase
      end
      count = 0;
      az = 1'b0;
      if (ntt_form) begin
        st = StNtt;
      end else if (failed) begin
        st = StParse;
      end else begin
        count = first_count;
        if (first_count == 0 || !any_nonzero) begin
          st = StOk;
          az = 1'b1;
        end else if (coef_wide) begin
          st = StWide;
        end else begin
          st = StOk;
        end
      end
      push_result(KindSummary, 0, '0, count, az, st, 1'b1);
      restart();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares one output transaction against the oldest outstanding result.
    function void check_result(logic kind, logic [103:0] data, logic last_flag);
      poly_result_t e;
      if (due_results.size() == 0) begin
        $error("result with nothing outstanding: kind %0h, tdata %0h", kind, data);
        errors++;
        return;
      end
      e = due_results.pop_front();
      compare_field("result_kind", e.kind, kind);
      compare_field("term_power", e.power, data[15:0]);
      compare_field("term_coefficient", e.coef, data[79:16]);
      compare_field("coefficient_count", e.count, data[96:80]);
      compare_field("all_zero", e.all_zero, data[97]);
      compare_field("status", e.status, data[99:98]);
      compare_field("last", e.last, last_flag);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_wdata = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  parse_scoreboard sb;
  bit              idle_on = 1'b1;
  bit              hold_req = 1'b0;
  logic [7:0]      text_q[$];
  int              stall_cycles = 0;

  hex_polynomial_text_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #HalfPeriod clk = ~clk;
  end

  // Offers one request, with an optional idle burst first, and waits for its transaction.
  task automatic offer(logic req, logic [7:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= c;
    do @(posedge clk); while (!s_tready);
    sb.note_request(req, c);
  endtask

  task automatic send_text();
    foreach (text_q[i]) offer(ReqChar, text_q[i]);
    offer(ReqEnd, 8'($urandom_range(0, 255)));
  endtask

  // Stops offering until every outstanding result has come out and the pipe is empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.ntt_form = v;
  endtask

  function automatic void load_text(string s);
    int i;
    text_q.delete();
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic string hex_char(bit nonzero);
    string alph;
    int k;
    alph = "0123456789abcdefABCDEF";
    k = $urandom_range(nonzero ? 1 : 0, 21);
    return alph.substr(k, k);
  endfunction

  // Coefficient text: mostly short, with all-zero, maximal, padded and too-wide ones.
  function automatic string coef_text();
    string s;
    string fch;
    int n;
    int i;
    s = "";
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) s = {s, "0"};
      end
      1: begin
        if ($urandom_range(0, 1) == 1) s = "0";
        s = {s, hex_char(1'b1)};
        n = $urandom_range(16, 17);
        for (i = 0; i < n; i++) s = {s, hex_char(1'b0)};
      end
      2: begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) s = {s, "0"};
        s = {s, hex_char(1'b1)};
        for (i = 0; i < 15; i++) s = {s, hex_char(1'b0)};
      end
      3: begin
        for (i = 0; i < 16; i++) begin
          if ($urandom_range(0, 1) == 1) fch = "F";
          else fch = "f";
          s = {s, fch};
        end
      end
      default: begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) s = {s, hex_char(1'b0)};
      end
    endcase
    return s;
  endfunction

  // Builds one string: well formed, with noise, with a bad power, or random bytes.
  function automatic void compose(int mode);
    string s;
    string ptext;
    int nterms;
    int bad;
    int prev;
    int pw;
    int k;
    int pos;
    bit powered;
    s = "";
    nterms = $urandom_range(mode == 2 ? 1 : 0, 4);
    bad = (mode == 2) ? $urandom_range(0, nterms - 1) : -1;
    prev = PowerLimit;
    for (k = 0; k < nterms; k++) begin
      s = {s, coef_text()};
      powered = 1'b1;
      if (k == bad) begin
        // Repeated, rising or saturating power.
        if ($urandom_range(0, 3) == 0) ptext = "99999999999";
        else ptext = $sformatf("%0d", prev + $urandom_range(0, 2));
        s = {s, "x^", ptext};
      end else if (k == nterms - 1 && $urandom_range(0, 3) == 0) begin
        // A bare coefficient closes the string with power zero.
        powered = 1'b0;
      end else begin
        if (k == 0) begin
          case ($urandom_range(0, 7))
            0: pw = PowerLimit - 1;
            1: pw = $urandom_range(0, PowerLimit - 1);
            default: pw = $urandom_range(0, 40);
          endcase
        end else if ($urandom_range(0, 1) == 1) begin
          pw = $urandom_range(0, prev - 1);
        end else begin
          pw = prev - 1 - $urandom_range(0, (prev - 1 < 3) ? prev - 1 : 3);
        end
        if (pw == 0 && $urandom_range(0, 1) == 1) ptext = "";
        else if ($urandom_range(0, 7) == 0) ptext = $sformatf("0%0d", pw);
        else ptext = $sformatf("%0d", pw);
        s = {s, "x^", ptext};
        prev = pw;
        if (pw == 0) nterms = k + 1;
      end
      if (k < nterms - 1 || (powered && $urandom_range(0, 5) == 0)) s = {s, " + "};
    end
    load_text(s);
    if (mode == 1) begin
      repeat ($urandom_range(1, 2)) begin
        pos = $urandom_range(0, text_q.size());
        if (pos < text_q.size() && $urandom_range(0, 1) == 1)
          text_q[pos] = 8'($urandom_range(0, 255));
        else
          text_q.insert(pos, 8'($urandom_range(0, 255)));
      end
    end
    if (mode == 3) begin
      text_q.delete();
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Main sequence: reset, directed strings, then random phases per mode setting.
  initial begin
    int ph;
    int goal;
    int r;
    bit opening;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_mode(1'b0);
    load_text("");
    send_text();
    load_text("0");
    send_text();
    load_text("Bx^ + ");
    send_text();
    text_q.delete();
    text_q.push_back(8'h00);
    send_text();
    load_text("fFx^65535 + 0");
    send_text();
    write_mode(1'b1);
    load_text("5");
    send_text();

    for (ph = 0; ph < 4; ph++) begin
      write_mode(ph % 2 == 0);
      idle_on = (ph != 3);
      goal = sb.live_items + PhaseItems;
      opening = 1'b1;
      while (sb.live_items < goal) begin
        if ((ph == 1 && opening) || (idle_on && $urandom_range(0, 39) == 0)) hold_req = 1'b1;
        if ($urandom_range(0, 24) == 0) drain();
        r = $urandom_range(0, 9);
        compose(r < 7 ? 0 : r - 6);
        send_text();
        opening = 1'b0;
      end
    end

    drain();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: long hold-offs on request, random stall bursts otherwise.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
